@@ rtl/dss_pkg.sv @@
// Shared constants, types and control structures for the duplicate-free set store.
package dss_pkg;

    localparam int CAPACITY = 128;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam int GRP_SIZE   = 16;
    localparam int GRP_W      = 4;
    localparam int NUM_GROUPS = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GSEL_W     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int PAD_W      = NUM_GROUPS * GRP_SIZE;

    localparam int VALUE_W = 32;
    localparam int OUT_CNT_W = 8;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;

    typedef struct packed {
        logic             ins_en;
        logic             del_en;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] del_idx;
    } cell_ctrl_t;

    typedef struct packed {
        logic             hit_any;
        logic [IDX_W-1:0] hit_idx;
    } enc_out_t;

endpackage

@@ rtl/dedup_set_store_core.sv @@
// Top level of the duplicate-free set store: cell chain, hit encoder and operation control.
// An accepted operation walks through the compare, two-stage hit reduction and update
// steps, and the update loads its result beat into the output register; the update
// waits while an unread result is held, and the next operation is taken only after it.
// A pending result waits in the output register while the next operation is accepted.
// Reset empties the set; the cell contents are not cleared and are never read while unused.
module dedup_set_store_core
    import dss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             op,
    input  logic signed [31:0]     value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   was_member,
    output logic [OUT_CNT_W-1:0]   entry_count,
    output logic                   is_empty,
    output logic                   is_full,
    output logic                   insert_refused
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CMP   = 5'b00010,
        S_GRP   = 5'b00100,
        S_ENC   = 5'b01000,
        S_APPLY = 5'b10000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [1:0]         op_reg;
    logic [VALUE_W-1:0] query_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               was_member_reg;
    logic [CNT_W-1:0]   res_count_reg;
    logic               refused_reg;

    logic               in_fire;
    logic               apply_fire;
    logic               is_ins;
    logic               is_del;
    logic               do_ins;
    logic               do_del;
    logic               refused;
    logic               set_full;

    logic [VALUE_W-1:0]  cell_val [CAPACITY];
    logic [CAPACITY-1:0] cell_hit;
    cell_ctrl_t          ctrl;
    enc_out_t            enc;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign apply_fire = (state_reg == S_APPLY) && (!out_valid_reg || out_ready);

    assign is_ins   = (op_reg == OP_INSERT);
    assign is_del   = (op_reg == OP_DELETE);
    assign set_full = (count_reg >= CNT_W'(CAPACITY));
    assign do_ins   = is_ins && !enc.hit_any && !set_full;
    assign refused  = is_ins && !enc.hit_any && set_full;
    assign do_del   = is_del && enc.hit_any;

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_del)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        ctrl.ins_en  = apply_fire && do_ins;
        ctrl.del_en  = apply_fire && do_del;
        ctrl.count   = count_reg;
        ctrl.del_idx = enc.hit_idx;
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [VALUE_W-1:0] right_val;
            if (i == CAPACITY - 1)
            begin : g_last
                assign right_val = cell_val[i];
            end
            else
            begin : g_mid
                assign right_val = cell_val[i+1];
            end

            dss_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cell_idx  (IDX_W'(i)),
                .query     (query_reg),
                .ctrl      (ctrl),
                .right_val (right_val),
                .val       (cell_val[i]),
                .hit       (cell_hit[i])
            );
        end
    endgenerate

    dss_hit_enc u_hit_enc (
        .clk   (clk),
        .rst_n (rst_n),
        .hits  (cell_hit),
        .enc   (enc)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:   state_next = S_GRP;
            S_GRP:   state_next = S_ENC;
            S_ENC:   state_next = S_APPLY;
            S_APPLY:
            begin
                if (apply_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (apply_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (apply_fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= op;
            query_reg <= VALUE_W'(unsigned'(value));
        end
        if (apply_fire)
        begin
            was_member_reg <= enc.hit_any;
            res_count_reg  <= count_next;
            refused_reg    <= refused;
        end
    end

    assign out_valid      = out_valid_reg;
    assign was_member     = was_member_reg;
    assign entry_count    = OUT_CNT_W'(res_count_reg);
    assign is_empty       = (res_count_reg == '0);
    assign is_full        = (res_count_reg == CNT_W'(CAPACITY));
    assign insert_refused = refused_reg;

endmodule

@@ rtl/dss_cell.sv @@
// One storage cell of the chain: holds a value, compares it and shifts it to its neighbor.
module dss_cell
    import dss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IDX_W-1:0]     cell_idx,
    input  logic [VALUE_W-1:0]   query,
    input  cell_ctrl_t           ctrl,
    input  logic [VALUE_W-1:0]   right_val,
    output logic [VALUE_W-1:0]   val,
    output logic                 hit
);

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               hit_reg;
    logic               hit_next;
    logic               in_use;

    assign in_use   = CNT_W'(cell_idx) < ctrl.count;
    assign hit_next = in_use && (value_reg == query);

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins_en && (CNT_W'(cell_idx) == ctrl.count))
        begin
            value_next = query;
        end
        else if (ctrl.del_en && (cell_idx >= ctrl.del_idx))
        begin
            value_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign val = value_reg;
    assign hit = hit_reg;

endmodule

@@ rtl/dss_hit_enc.sv @@
// Two-stage registered reduction that turns the per-cell match bits into a hit flag and index.
module dss_hit_enc
    import dss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CAPACITY-1:0] hits,
    output enc_out_t            enc
);

    logic [PAD_W-1:0]      hits_pad;
    logic [NUM_GROUPS-1:0] grp_any_reg;
    logic [NUM_GROUPS-1:0] grp_any_next;
    logic [GRP_W-1:0]      grp_idx_reg  [NUM_GROUPS];
    logic [GRP_W-1:0]      grp_idx_next [NUM_GROUPS];
    logic [GSEL_W+GRP_W-1:0] idx_full;
    enc_out_t              enc_reg;
    enc_out_t              enc_next;

    always_comb
    begin
        hits_pad = '0;
        hits_pad[CAPACITY-1:0] = hits;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_any_next[g] = 1'b0;
            grp_idx_next[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++)
            begin
                if (hits_pad[g*GRP_SIZE + j])
                begin
                    grp_any_next[g] = 1'b1;
                    grp_idx_next[g] = grp_idx_next[g] | GRP_W'(j);
                end
            end
        end
    end

    always_comb
    begin
        idx_full = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            if (grp_any_reg[g])
            begin
                idx_full = idx_full | {GSEL_W'(g), grp_idx_reg[g]};
            end
        end
        enc_next.hit_any = |grp_any_reg;
        enc_next.hit_idx = idx_full[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_any_reg <= '0;
            enc_reg     <= '0;
        end
        else
        begin
            grp_any_reg <= grp_any_next;
            enc_reg     <= enc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_idx_reg[g] <= grp_idx_next[g];
        end
    end

    assign enc = enc_reg;

endmodule
